// ----- rtl/mss_pkg.sv -----
// Package with shared types and constants of the multipath slot selector.
package mss_pkg;

    localparam int NumSlotsDefault = 64;

    typedef enum logic [1:0] {
        LB_ECMP     = 2'd0,
        LB_SPRAY    = 2'd1,
        LB_FLOWCELL = 2'd2,
        LB_ECMP_ONLY = 2'd3
    } lb_mode_t;

    typedef enum logic [2:0] {
        CFG_LB_MODE   = 3'd0,
        CFG_SEL_SPRAY = 3'd1,
        CFG_FULL_FAIL = 3'd2,
        CFG_FAT_TREE_K = 3'd3,
        CFG_ADDR_SHIFT = 3'd4,
        CFG_ADDR_MASK = 3'd5,
        CFG_MAX_SLOT  = 3'd6,
        CFG_VALID_MASK = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_SEARCH,
        ST_OUT
    } state_t;

    // How the slot of the current item is found.
    typedef enum logic [1:0] {
        SEL_HASH   = 2'd0,
        SEL_SEARCH = 2'd1,
        SEL_DIRECT = 2'd2
    } sel_kind_t;

    // Start and done handshake of the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [7:0]  remainder;
    } div_rsp_t;

endpackage

// ----- rtl/mss_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared for all modulos.
module mss_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  mss_pkg::div_req_t req,
    output mss_pkg::div_rsp_t rsp
);
    import mss_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [8:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic        done_reg, done_next;
    logic [8:0]  trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[7:0], quo_reg[31]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            quo_next  = req.dividend;
            rem_next  = 9'd0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // Shift the next dividend bit in and subtract where it fits.
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[7:0];

endmodule

// ----- rtl/multipath_slot_selector_unit.sv -----
// Top level of the multipath slot selector with its sequencer.
// Sequence: an accept step, the hash over the key bytes and a launch step (ECMP), one
// division through the shared divider (two in series at a fat-tree ToR), a search over up to
// NUM_SLOTS slots, then the result sits in the output register until taken.
// One item is handled at a time: a new one is accepted only in idle.
// Reset (aresetn low, synchronous) restores register defaults and clears the spray pointer.
module multipath_slot_selector_unit #(
    parameter int NUM_SLOTS = mss_pkg::NumSlotsDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_addr, dst_addr, src_port, dst_port, flow_ident, hop_limit,
    // is_elephant, visited_tor, agg_choice_in, link_ident, failure_seen
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // chosen_slot, choice_valid, visited_tor_out, agg_choice_out
    output logic [15:0]  m_tdata
);
    import mss_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    logic [1:0]  lb_mode_reg;
    logic        sel_spray_reg, full_fail_reg;
    logic [7:0]  ft_k_reg;
    logic [4:0]  addr_shift_reg;
    logic [31:0] addr_mask_reg;
    logic [5:0]  max_slot_reg;
    logic [63:0] valid_mask_reg;

    state_t state_reg, state_next;
    logic [SW-1:0] spray_ptr_reg, spray_ptr_next;
    logic [191:0] key_reg, key_next;
    logic [31:0] hash_reg, hash_next;
    logic [4:0]  bcnt_reg, bcnt_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [CW-1:0] left_reg, left_next;
    logic        vis_reg;
    logic [7:0]  agg_reg;
    logic        vis_out_reg, vis_out_next;
    logic [7:0]  agg_out_reg, agg_out_next;
    sel_kind_t   kind_reg, kind_next;
    logic [5:0]  slot_out_reg, slot_out_next;
    logic        cv_reg, cv_next;
    logic        upd_reg, upd_next;
    logic        div_phase_reg, div_phase_next;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic [CW-1:0] n_full;
    logic [7:0]    n8;
    logic [31:0]   srcs, dsts;
    logic [7:0]    byte_c;
    logic [SW-1:0] nxt_cur;

    always_comb begin
        n_full = CW'({1'b0, max_slot_reg} + 7'd1);
        if ({1'b0, max_slot_reg} + 7'd1 > 7'(NUM_SLOTS)) n_full = CW'(NUM_SLOTS);
    end
    assign n8 = 8'(n_full);
    assign byte_c = key_reg[7:0];
    assign nxt_cur = (CW'(cur_reg) + CW'(1) >= n_full) ? '0 : cur_reg + SW'(1);
    assign srcs = (s_tdata[31:0] >> addr_shift_reg) & addr_mask_reg;
    assign dsts = (s_tdata[63:32] >> addr_shift_reg) & addr_mask_reg;

    mss_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lb_mode_reg <= 2'd0; sel_spray_reg <= 1'b0; full_fail_reg <= 1'b0;
            ft_k_reg <= 8'd0; addr_shift_reg <= 5'd0; addr_mask_reg <= '1;
            max_slot_reg <= 6'd0; valid_mask_reg <= '0;
            state_reg <= ST_IDLE; spray_ptr_reg <= '0;
        end else begin
            state_reg <= state_next;
            spray_ptr_reg <= spray_ptr_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_LB_MODE:    lb_mode_reg <= cfg_data[1:0];
                    CFG_SEL_SPRAY:  sel_spray_reg <= cfg_data[0];
                    CFG_FULL_FAIL:  full_fail_reg <= cfg_data[0];
                    CFG_FAT_TREE_K: ft_k_reg <= cfg_data[7:0];
                    CFG_ADDR_SHIFT: addr_shift_reg <= cfg_data[4:0];
                    CFG_ADDR_MASK:  addr_mask_reg <= cfg_data[31:0];
                    CFG_MAX_SLOT:   max_slot_reg <= cfg_data[5:0];
                    CFG_VALID_MASK: valid_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        key_reg <= key_next; hash_reg <= hash_next; bcnt_reg <= bcnt_next;
        cur_reg <= cur_next;
        left_reg <= left_next; vis_out_reg <= vis_out_next;
        agg_out_reg <= agg_out_next; kind_reg <= kind_next;
        slot_out_reg <= slot_out_next; cv_reg <= cv_next; upd_reg <= upd_next;
        div_phase_reg <= div_phase_next;
        if (s_tvalid && s_tready) begin
            vis_reg <= s_tdata[137];
            agg_reg <= s_tdata[145:138];
        end
    end

    always_comb begin
        state_next = state_reg; spray_ptr_next = spray_ptr_reg;
        key_next = key_reg; hash_next = hash_reg; bcnt_next = bcnt_reg;
        cur_next = cur_reg;
        left_next = left_reg; vis_out_next = vis_out_reg;
        agg_out_next = agg_out_reg; kind_next = kind_reg;
        slot_out_next = slot_out_reg; cv_next = cv_reg; upd_next = upd_reg;
        div_phase_next = div_phase_reg;
        dreq = '{start: 1'b0, dividend: hash_reg, divisor: n8};
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // Key words from low to high: sport, dport, src, dst, fid, ttl.
                    key_next = {24'd0, s_tdata[135:128], s_tdata[127:96], dsts, srcs,
                                16'd0, s_tdata[95:80], 16'd0, s_tdata[79:64]};
                    hash_next = 32'd0; bcnt_next = 5'd0;
                    vis_out_next = s_tdata[137]; agg_out_next = s_tdata[145:138];
                    cv_next = 1'b1; upd_next = 1'b0; kind_next = SEL_HASH;
                    if (lb_mode_reg == LB_ECMP || (lb_mode_reg != LB_SPRAY
                            && !s_tdata[136])) begin
                        state_next = ST_HASH;
                    end else if (lb_mode_reg == LB_SPRAY) begin
                        upd_next = 1'b1;
                        state_next = ST_DIV3;
                        dreq.start = 1'b1;
                        if (sel_spray_reg && s_tdata[152]) begin
                            kind_next = SEL_DIRECT;
                            dreq.dividend = 32'(s_tdata[151:146]);
                        end else begin
                            kind_next = SEL_SEARCH;
                            dreq.dividend = 32'(spray_ptr_reg);
                        end
                    end else if (lb_mode_reg == LB_FLOWCELL) begin
                        upd_next = 1'b1;
                        kind_next = full_fail_reg ? SEL_SEARCH : SEL_DIRECT;
                        state_next = ST_DIV3;
                        dreq.start = 1'b1;
                        dreq.dividend = 32'(s_tdata[151:146]);
                    end else begin
                        cv_next = 1'b0; slot_out_next = 6'd0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_HASH: begin
                hash_next = (hash_reg << 3) + hash_reg + {{24{byte_c[7]}}, byte_c};
                key_next = key_reg >> 8;
                bcnt_next = bcnt_reg + 5'd1;
                if (bcnt_reg == 5'd23) state_next = ST_DIV1;
            end
            ST_DIV1: begin
                // Launch hash mod n, hash mod k, or agg mod n.
                dreq.start = 1'b1;
                div_phase_next = 1'b0;
                if (ft_k_reg == 8'd0) begin
                    state_next = ST_DIV3;
                end else if (vis_reg) begin
                    vis_out_next = 1'b0;
                    dreq.dividend = 32'(agg_reg);
                    state_next = ST_DIV3;
                end else begin
                    dreq.divisor = ft_k_reg;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (drsp.done) begin
                    dreq.start = 1'b1;
                    dreq.dividend = 32'(drsp.remainder);
                    vis_out_next = 1'b1;
                    div_phase_next = 1'b1;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (drsp.done) begin
                    if (div_phase_reg) agg_out_next = drsp.quotient[7:0];
                    div_phase_next = 1'b0;
                    cur_next = SW'(drsp.remainder);
                    left_next = n_full;
                    if (kind_reg == SEL_DIRECT) begin
                        slot_out_next = 6'(drsp.remainder);
                        spray_ptr_next = SW'(drsp.remainder);
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // One slot examined per cycle; the last one is taken if none valid.
                if (valid_mask_reg[cur_reg] || left_reg == CW'(1)) begin
                    slot_out_next = 6'(cur_reg);
                    if (upd_reg) spray_ptr_next = nxt_cur;
                    state_next = ST_OUT;
                end else begin
                    cur_next = nxt_cur;
                    left_next = left_reg - CW'(1);
                end
            end
            ST_OUT: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {agg_out_reg, vis_out_reg, cv_reg, slot_out_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SEARCH |-> left_reg != '0) else $error("search overran");
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, spray_ptr_reg} < (SW+1)'(NUM_SLOTS)) else $error("pointer out of range");

endmodule
